// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the CSV field extractor.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/csvfx_pkg.sv =====
// Package for the CSV field extractor: sizes, character codes, register
// indexes, the result record and the whitespace test. No dependencies.
package csvfx_pkg;

  localparam int BLANK_DEPTH = 16;
  localparam int INDEX_WIDTH = 16;
  localparam int BLANK_AW    = (BLANK_DEPTH > 1) ? $clog2(BLANK_DEPTH) : 1;
  localparam int BLANK_CW    = $clog2(BLANK_DEPTH + 1);
  localparam int CHAR_W      = 8;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 16;
  localparam int FIELD_IDX_W = 16;

  localparam logic [CHAR_W-1:0] CH_COMMA = 8'd44;
  localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'd34;
  localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'd39;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
  localparam logic [CHAR_W-1:0] CH_CR = 8'd13;

  localparam logic [CFG_IDX_W-1:0] REG_FIELD_INDEX = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_BLANKS = 8'd1;

  typedef enum logic [1:0] {
    QUOTE_NONE = 2'd0,
    QUOTE_DBL  = 2'd1,
    QUOTE_SGL  = 2'd2
  } quote_t;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              char_valid;
    logic              field_end;
    logic              field_missing;
    logic              blank_overflow;
  } result_t;

  function automatic logic is_blank(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

// ===== hdl/csvfx_if.sv =====
// Valid/ready channel interfaces of the CSV field extractor: input bytes,
// result items and register writes. Depends on csvfx_pkg.
interface csvfx_in_if;
  import csvfx_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] ch;
  logic              is_terminator;
  modport source (output valid, ch, is_terminator, input ready);
  modport sink (input valid, ch, is_terminator, output ready);
endinterface

interface csvfx_out_if;
  import csvfx_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              char_valid;
  logic              field_end;
  logic              field_missing;
  logic              blank_overflow;
  modport source (output valid, out_char, char_valid, field_end, field_missing,
                  blank_overflow, input ready);
  modport sink (input valid, out_char, char_valid, field_end, field_missing,
                blank_overflow, output ready);
endinterface

interface csvfx_cfg_if;
  import csvfx_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/csv_field_extractor_top.sv =====
// CSV field extractor top level: emits one field of a comma-separated byte list.
// Each result is registered in the output register, or in the skid stage if that is held.
// Takes one byte per cycle unless draining or the skid stage is full; a content byte
// behind k held blanks gives k+1 results (blanks, then the byte) and holds input until done.
// Reset: synchronous rst_n clears config, list, drain and valid state; not data or blanks.
// Depends on csvfx_pkg, csvfx_if.sv and assert_macros.svh.
`include "assert_macros.svh"

module csv_field_extractor_top (
  input logic         clk,
  input logic         rst_n,
  csvfx_in_if.sink    in_bus,
  csvfx_out_if.source out_bus,
  csvfx_cfg_if.sink   cfg_bus
);
  import csvfx_pkg::*;

  // configuration
  logic [FIELD_IDX_W-1:0] field_index_r;
  logic                   keep_blanks_r;

  // list state
  logic [INDEX_WIDTH-1:0] field_counter_r, field_counter_nxt;
  quote_t                 quote_r, quote_nxt;
  logic                   close_pending_r, close_pending_nxt;
  logic                   content_seen_r, content_seen_nxt;
  logic                   field_done_r, field_done_nxt;
  logic                   field_started_r, field_started_nxt;
  logic                   overflow_r, overflow_nxt;
  logic [BLANK_CW-1:0]    blank_count_r, blank_count_nxt;
  logic [CHAR_W-1:0]      blank_fifo_r [BLANK_DEPTH];

  // drain of held blanks
  logic                   flush_busy_r;
  logic [BLANK_CW-1:0]    flush_idx_r;
  logic [BLANK_CW-1:0]    flush_cnt_r;
  logic [CHAR_W-1:0]      held_char_r;
  logic [CHAR_W-1:0]      flush_rd_r;

  // output register and skid stage
  logic                   out_valid_r, skid_valid_r;
  result_t                out_item_r, skid_item_r;

  logic                   in_ready;
  logic                   in_acc;
  logic                   flush_adv;
  logic                   step_push;
  result_t                step_item;
  logic                   start_flush;
  logic                   fifo_we;
  logic                   push;
  result_t                push_item;
  result_t                flush_item;
  logic                   out_free;

  logic [INDEX_WIDTH-1:0] index_cmp;
  logic                   target;
  logic [CHAR_W-1:0]      qc;
  logic                   unquoted;

  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_index_r <= '0;
      keep_blanks_r <= 1'b0;
    end else if (cfg_bus.valid) begin
      unique case (cfg_bus.index)
        REG_FIELD_INDEX: field_index_r <= cfg_bus.data[FIELD_IDX_W-1:0];
        REG_KEEP_BLANKS: keep_blanks_r <= cfg_bus.data[0];
        default: ;
      endcase
    end
  end

  assign in_ready       = !flush_busy_r && !skid_valid_r;
  assign in_bus.ready   = in_ready;
  assign in_acc         = in_bus.valid && in_ready;
  assign flush_adv      = flush_busy_r && !skid_valid_r;

  assign index_cmp = INDEX_WIDTH'(field_index_r);
  assign target    = (field_counter_r == index_cmp);
  assign qc        = (quote_r == QUOTE_DBL) ? CH_DQUOTE : CH_SQUOTE;

  // Work out the effect of the presented byte; registered only on acceptance.
  always_comb begin
    field_counter_nxt = field_counter_r;
    quote_nxt         = quote_r;
    close_pending_nxt = close_pending_r;
    content_seen_nxt  = content_seen_r;
    field_done_nxt    = field_done_r;
    field_started_nxt = field_started_r;
    overflow_nxt      = overflow_r;
    blank_count_nxt   = blank_count_r;
    step_push         = 1'b0;
    start_flush       = 1'b0;
    fifo_we           = 1'b0;
    unquoted          = 1'b0;
    step_item         = '{out_char: '0, char_valid: 1'b0, field_end: 1'b0,
                          field_missing: 1'b0, blank_overflow: overflow_r};

    if (in_bus.is_terminator) begin
      if (!field_done_r) begin
        step_push               = 1'b1;
        step_item.field_end     = 1'b1;
        step_item.field_missing = target ? !field_started_r : 1'b1;
      end
      field_counter_nxt = '0;
      quote_nxt         = QUOTE_NONE;
      close_pending_nxt = 1'b0;
      content_seen_nxt  = 1'b0;
      field_done_nxt    = 1'b0;
      field_started_nxt = 1'b0;
      overflow_nxt      = 1'b0;
      blank_count_nxt   = '0;
    end else if (!field_done_r) begin
      if (target) begin
        field_started_nxt = 1'b1;
      end
      priority if (close_pending_r) begin
        close_pending_nxt = 1'b0;
        if (in_bus.ch == qc) begin
          // doubled quote: one literal quote mark
          if (target) begin
            step_item.out_char   = in_bus.ch;
            step_item.char_valid = 1'b1;
            content_seen_nxt     = 1'b1;
            blank_count_nxt      = '0;
            if (blank_count_r != '0) begin
              start_flush = 1'b1;
            end else begin
              step_push = 1'b1;
            end
          end
        end else begin
          quote_nxt = QUOTE_NONE;
          unquoted  = 1'b1;
        end
      end else if (quote_r != QUOTE_NONE) begin
        if (in_bus.ch == qc) begin
          close_pending_nxt = 1'b1;
        end else if (target) begin
          step_item.out_char   = in_bus.ch;
          step_item.char_valid = 1'b1;
          content_seen_nxt     = 1'b1;
          blank_count_nxt      = '0;
          if (blank_count_r != '0) begin
            start_flush = 1'b1;
          end else begin
            step_push = 1'b1;
          end
        end
      end else begin
        unquoted = 1'b1;
      end

      if (unquoted) begin
        priority if (in_bus.ch == CH_DQUOTE) begin
          quote_nxt = QUOTE_DBL;
        end else if (in_bus.ch == CH_SQUOTE) begin
          quote_nxt = QUOTE_SGL;
        end else if (in_bus.ch == CH_COMMA) begin
          if (target) begin
            // end of the wanted field: drop held blanks
            blank_count_nxt     = '0;
            step_push           = 1'b1;
            step_item.field_end = 1'b1;
            field_done_nxt      = 1'b1;
          end else if (field_counter_r != {INDEX_WIDTH{1'b1}}) begin
            field_counter_nxt = field_counter_r + 1'b1;
          end
        end else if (!target) begin
          // byte of another field
        end else if (!keep_blanks_r && is_blank(in_bus.ch)) begin
          if (content_seen_r) begin
            if (blank_count_r < BLANK_CW'(BLANK_DEPTH)) begin
              fifo_we         = 1'b1;
              blank_count_nxt = blank_count_r + 1'b1;
            end else begin
              overflow_nxt = 1'b1;
            end
          end
        end else begin
          step_item.out_char   = in_bus.ch;
          step_item.char_valid = 1'b1;
          content_seen_nxt     = 1'b1;
          blank_count_nxt      = '0;
          if (blank_count_r != '0) begin
            start_flush = 1'b1;
          end else begin
            step_push = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_counter_r <= '0;
      quote_r         <= QUOTE_NONE;
      close_pending_r <= 1'b0;
      content_seen_r  <= 1'b0;
      field_done_r    <= 1'b0;
      field_started_r <= 1'b0;
      overflow_r      <= 1'b0;
      blank_count_r   <= '0;
    end else if (in_acc) begin
      field_counter_r <= field_counter_nxt;
      quote_r         <= quote_nxt;
      close_pending_r <= close_pending_nxt;
      content_seen_r  <= content_seen_nxt;
      field_done_r    <= field_done_nxt;
      field_started_r <= field_started_nxt;
      overflow_r      <= overflow_nxt;
      blank_count_r   <= blank_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && fifo_we) begin
      blank_fifo_r[blank_count_r[BLANK_AW-1:0]] <= in_bus.ch;
    end
  end

  // Drain held blanks in order, then the content byte that released them.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flush_busy_r <= 1'b0;
      flush_idx_r  <= '0;
      flush_cnt_r  <= '0;
    end else if (in_acc && start_flush) begin
      flush_busy_r <= 1'b1;
      flush_idx_r  <= '0;
      flush_cnt_r  <= blank_count_r;
    end else if (flush_adv) begin
      if (flush_idx_r == flush_cnt_r) begin
        flush_busy_r <= 1'b0;
      end else begin
        flush_idx_r <= flush_idx_r + 1'b1;
      end
    end
  end

  // Register the content byte, and the next held blank ahead of its turn.
  always_ff @(posedge clk) begin
    if (in_acc && start_flush) begin
      held_char_r <= in_bus.ch;
      flush_rd_r  <= blank_fifo_r[{BLANK_AW{1'b0}}];
    end else if (flush_adv && (flush_idx_r != flush_cnt_r)) begin
      flush_rd_r <= blank_fifo_r[BLANK_AW'(flush_idx_r + 1'b1)];
    end
  end

  always_comb begin
    flush_item = '{out_char: held_char_r, char_valid: 1'b1, field_end: 1'b0,
                   field_missing: 1'b0, blank_overflow: overflow_r};
    if (flush_idx_r != flush_cnt_r) begin
      flush_item.out_char = flush_rd_r;
    end
  end

  assign push      = flush_adv || (in_acc && step_push);
  assign push_item = flush_busy_r ? flush_item : step_item;
  assign out_free  = !out_valid_r || out_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_bus.ready) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (out_free) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_bus.ready) begin
        out_item_r <= skid_item_r;
      end
    end else if (push) begin
      if (out_free) begin
        out_item_r <= push_item;
      end else begin
        skid_item_r <= push_item;
      end
    end
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.out_char       = out_item_r.out_char;
  assign out_bus.char_valid     = out_item_r.char_valid;
  assign out_bus.field_end      = out_item_r.field_end;
  assign out_bus.field_missing  = out_item_r.field_missing;
  assign out_bus.blank_overflow = out_item_r.blank_overflow;

  `ASSERT_SAME(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r, "skid full while output empty")
  `ASSERT_SAME(a_flush_idx_range, clk, rst_n, flush_busy_r, flush_idx_r <= flush_cnt_r, "drain index past count")
  `ASSERT_SAME(a_blank_count_range, clk, rst_n, 1'b1, blank_count_r <= BLANK_CW'(BLANK_DEPTH), "blank count past depth")
  `ASSERT_SAME(a_end_has_no_char, clk, rst_n, out_valid_r && out_item_r.field_end, !out_item_r.char_valid, "end result carries a character")
  `ASSERT_NEXT(a_term_clears_counter, clk, rst_n, in_acc && in_bus.is_terminator, field_counter_r == '0 && !field_done_r, "list state not cleared")

endmodule
